// ----- rtl/core/bpa_pkg.sv -----
// Shared definitions for the bitmap page allocator: field widths, codes,
// the microcode program and its control word, and bitmap helper functions.
// No dependencies.
package bpa_pkg;

  localparam int PAGE_COUNT = 512;
  localparam int WORD_BITS  = 32;

  localparam int CFG_W      = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int PAGE_W     = 9;
  localparam int COUNT_W    = 10;
  localparam int MODE_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int STEP_W     = 3;
  localparam int ACT_W      = 3;
  localparam int COND_W     = 3;

  // Item modes.
  localparam logic [MODE_W-1:0] MODE_INIT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FREE  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NOP   = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FREE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FREE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL      = 2'd1;

  // Microprogram steps.
  localparam logic [STEP_W-1:0] S_FETCH   = 3'd0;
  localparam logic [STEP_W-1:0] S_INIT    = 3'd1;
  localparam logic [STEP_W-1:0] S_FREE_RD = 3'd2;
  localparam logic [STEP_W-1:0] S_FREE_WR = 3'd3;
  localparam logic [STEP_W-1:0] S_ALLOC   = 3'd4;
  localparam logic [STEP_W-1:0] S_SCAN    = 3'd5;
  localparam logic [STEP_W-1:0] S_POST    = 3'd6;

  // Datapath actions.
  localparam logic [ACT_W-1:0] A_NONE        = 3'd0;
  localparam logic [ACT_W-1:0] A_ACCEPT      = 3'd1;
  localparam logic [ACT_W-1:0] A_INIT_WORD   = 3'd2;
  localparam logic [ACT_W-1:0] A_FREE_RD     = 3'd3;
  localparam logic [ACT_W-1:0] A_FREE_WR     = 3'd4;
  localparam logic [ACT_W-1:0] A_ALLOC_START = 3'd5;
  localparam logic [ACT_W-1:0] A_SCAN        = 3'd6;
  localparam logic [ACT_W-1:0] A_POST        = 3'd7;

  // Jump conditions.
  localparam logic [COND_W-1:0] C_NEVER      = 3'd0;
  localparam logic [COND_W-1:0] C_ALWAYS     = 3'd1;
  localparam logic [COND_W-1:0] C_DISPATCH   = 3'd2;
  localparam logic [COND_W-1:0] C_LAST_WORD  = 3'd3;
  localparam logic [COND_W-1:0] C_COUNT_ZERO = 3'd4;
  localparam logic [COND_W-1:0] C_SCAN_DONE  = 3'd5;
  localparam logic [COND_W-1:0] C_OUT_FREE   = 3'd6;

  typedef struct packed {
    logic [ACT_W-1:0]  act;
    logic [COND_W-1:0] cond;
    logic              hold;    // stay on this step while the condition is false
    logic [STEP_W-1:0] target;
  } bpa_ctl_t;

  typedef struct packed {
    logic              in_xfer;
    logic [MODE_W-1:0] mode;
    logic              last_word;
    logic              count_zero;
    logic              scan_done;
    logic              out_free;
  } bpa_cond_t;

  function automatic bpa_ctl_t ucode_rom(input logic [STEP_W-1:0] step);
    bpa_ctl_t w;
    unique case (step)
      S_FETCH:   w = '{act: A_ACCEPT,      cond: C_DISPATCH,   hold: 1'b1, target: S_FETCH};
      S_INIT:    w = '{act: A_INIT_WORD,   cond: C_LAST_WORD,  hold: 1'b1, target: S_POST};
      S_FREE_RD: w = '{act: A_FREE_RD,     cond: C_NEVER,      hold: 1'b0, target: S_FETCH};
      S_FREE_WR: w = '{act: A_FREE_WR,     cond: C_ALWAYS,     hold: 1'b0, target: S_POST};
      S_ALLOC:   w = '{act: A_ALLOC_START, cond: C_COUNT_ZERO, hold: 1'b0, target: S_POST};
      S_SCAN:    w = '{act: A_SCAN,        cond: C_SCAN_DONE,  hold: 1'b1, target: S_POST};
      S_POST:    w = '{act: A_POST,        cond: C_OUT_FREE,   hold: 1'b1, target: S_FETCH};
      default:   w = '{act: A_NONE,        cond: C_ALWAYS,     hold: 1'b0, target: S_FETCH};
    endcase
    return w;
  endfunction

  function automatic logic [STEP_W-1:0] dispatch(input logic [MODE_W-1:0] mode);
    logic [STEP_W-1:0] s;
    unique case (mode)
      MODE_INIT:  s = S_INIT;
      MODE_ALLOC: s = S_ALLOC;
      MODE_FREE:  s = S_FREE_RD;
      MODE_NOP:   s = S_POST;
      default:    s = S_POST;
    endcase
    return s;
  endfunction

  // Bits of word w whose page number lies below thr.
  function automatic logic [WORD_BITS-1:0] word_mask(input logic [31:0] w,
                                                      input logic [CFG_W-1:0] thr);
    logic [31:0] tw;
    logic [WORD_BITS-1:0] m;
    tw = 32'(thr[CFG_W-1:5]);
    if (w < tw) begin
      m = '1;
    end else if (w == tw) begin
      m = (32'd1 << thr[4:0]) - 32'd1;
    end else begin
      m = '0;
    end
    return m;
  endfunction

  // Index of a one-hot word.
  function automatic logic [4:0] onehot_index(input logic [WORD_BITS-1:0] oh);
    logic [4:0] idx;
    idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (oh[i]) begin
        idx = idx | 5'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ----- rtl/core/bitmap_page_allocator.sv -----
// Top level of the bitmap page allocator: configuration registers, free
// bitmap memory with per-word valid bits, and the datapath run by bpa_seq.
// Uses bpa_pkg and bpa_seq.
//
//  channel  signals                              direction  moves
//  input    in_valid/in_ready, mode, page_in     in         one request
//  output   out_valid/out_ready, page_out,       out        one result
//           status, free_pages
//  config   cfg_valid/cfg_ready, cfg_index,      in         one register write
//           cfg_data
//
// One item at a time. A no-op goes straight to the output step; a free reads
// its bitmap word and writes it back; an allocate scans word by word, not at
// all when the count is zero; an initialize writes every word in use. The scan
// and the initialize fill go through the bitmap memory, one word a cycle.
// Reset clears the valid bits at once, so there is no clearing pass.
// A result waiting on out_ready holds the sequencer at its output step, and
// register writes are taken only while the block waits for an input transfer.
module bitmap_page_allocator
  import bpa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [MODE_W-1:0]    mode,
  input  logic [PAGE_W-1:0]    page_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [PAGE_W-1:0]    page_out,
  output logic [STATUS_W-1:0]  status,
  output logic [COUNT_W-1:0]   free_pages,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int NUM_WORDS = PAGE_COUNT / WORD_BITS;
  localparam int WIDX      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam logic [CFG_W-1:0] PAGE_CAP = (PAGE_COUNT > 1023) ? 10'd1023 : 10'(PAGE_COUNT);

  bpa_ctl_t  ctl;
  bpa_cond_t cond;

  logic [CFG_W-1:0]     first_free_page;
  logic [CFG_W-1:0]     total_pages;
  logic [COUNT_W-1:0]   free_count;
  logic [WIDX-1:0]      scan_word;
  logic [NUM_WORDS-1:0] valid;

  logic [WORD_BITS-1:0] mem [NUM_WORDS];
  logic [WORD_BITS-1:0] rdata;
  logic                 rvalid;

  logic [PAGE_W-1:0]    page_q;
  logic [WIDX-1:0]      cursor;
  logic [WIDX-1:0]      iter;
  logic [PAGE_W-1:0]    res_page;
  logic [STATUS_W-1:0]  res_status;

  logic [CFG_W-1:0]     t_eff;
  logic [CFG_W:0]       t_round;
  logic [5:0]           words_used;
  logic [31:0]          cursor_inc;
  logic [WIDX-1:0]      cursor_next;
  logic [WIDX-1:0]      start_w;
  logic [31:0]          page_word32;
  logic [WIDX-1:0]      page_word;
  logic                 page_ok;
  logic [WORD_BITS-1:0] rword;
  logic [WORD_BITS-1:0] scan_bits;
  logic [WORD_BITS-1:0] iso;
  logic                 found;
  logic [4:0]           bit_idx;
  logic [31:0]          alloc_page;
  logic [WORD_BITS-1:0] init_bits;
  logic [COUNT_W-1:0]   init_count;
  logic                 last_init;
  logic                 scan_last;
  logic                 out_free;
  logic                 in_xfer;

  logic [WIDX-1:0]      rd_addr;
  logic                 we;
  logic [WIDX-1:0]      waddr;
  logic [WORD_BITS-1:0] wdata;
  logic                 clear_valid;

  bpa_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .cond (cond),
    .ctl  (ctl)
  );

  assign in_ready  = (ctl.act == A_ACCEPT);
  assign in_xfer   = in_valid & in_ready;
  assign cfg_ready = in_ready;
  assign out_free  = ~out_valid | out_ready;

  // Page count in use and the number of bitmap words it covers.
  assign t_eff      = (total_pages > PAGE_CAP) ? PAGE_CAP : total_pages;
  assign t_round    = {1'b0, t_eff} + 11'd31;
  assign words_used = t_round[CFG_W:5];

  assign cursor_inc  = 32'(cursor) + 32'd1;
  assign cursor_next = (cursor_inc >= 32'(words_used)) ? '0 : cursor_inc[WIDX-1:0];
  assign start_w     = (32'(scan_word) < 32'(words_used)) ? scan_word : '0;

  assign page_word32 = 32'(page_q) >> 5;
  assign page_word   = page_word32[WIDX-1:0];
  assign page_ok     = {1'b0, page_q} < t_eff;

  // A word never written since reset or the last initialize reads as zero.
  assign rword     = rvalid ? rdata : '0;
  assign scan_bits = rword & word_mask(32'(cursor), t_eff);
  assign found     = |scan_bits;
  assign iso       = scan_bits & (~scan_bits + 32'd1);
  assign bit_idx   = onehot_index(iso);
  assign alloc_page = (32'(cursor) << 5) | 32'(bit_idx);

  assign init_bits  = word_mask(32'(cursor), t_eff) & ~word_mask(32'(cursor), first_free_page);
  assign init_count = (t_eff > first_free_page) ? (t_eff - first_free_page) : '0;
  assign last_init  = cursor_inc >= 32'(words_used);
  assign scan_last  = (32'(iter) + 32'd1) >= 32'(words_used);

  always_comb begin
    cond.in_xfer    = in_xfer;
    cond.mode       = mode;
    cond.last_word  = last_init;
    cond.count_zero = (free_count == '0);
    cond.scan_done  = found | scan_last;
    cond.out_free   = out_free;
  end

  // Memory port control.
  always_comb begin
    rd_addr     = cursor;
    we          = 1'b0;
    waddr       = cursor;
    wdata       = init_bits;
    clear_valid = 1'b0;
    unique case (ctl.act)
      A_INIT_WORD: begin
        we          = 1'b1;
        clear_valid = (cursor == '0);
      end
      A_FREE_RD: begin
        rd_addr = page_word;
      end
      A_FREE_WR: begin
        we    = page_ok;
        waddr = page_word;
        wdata = rword | (32'd1 << page_q[4:0]);
      end
      A_ALLOC_START: begin
        rd_addr = start_w;
      end
      A_SCAN: begin
        // Prefetch the next word while testing this one.
        rd_addr = cursor_next;
        we      = found;
        wdata   = rword & ~iso;
      end
      default: begin
        rd_addr = cursor;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata  <= mem[rd_addr];
    rvalid <= valid[rd_addr];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      first_free_page <= 10'd1;
      total_pages     <= 10'd512;
      free_count      <= '0;
      scan_word       <= '0;
      valid           <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_FIRST_FREE) begin
          first_free_page <= cfg_data;
        end else if (cfg_index == CFG_TOTAL) begin
          total_pages <= cfg_data;
        end
      end
      if (we) begin
        // The first word of an initialize drops every other word back to zero.
        if (clear_valid) begin
          valid <= {{(NUM_WORDS-1){1'b0}}, 1'b1};
        end else begin
          valid[waddr] <= 1'b1;
        end
      end
      if ((ctl.act == A_POST) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (ctl.act)
        A_INIT_WORD: begin
          free_count <= init_count;
        end
        A_FREE_WR: begin
          if (page_ok && (free_count < t_eff)) begin
            free_count <= free_count + 1'b1;
          end
        end
        A_SCAN: begin
          if (found) begin
            scan_word  <= cursor;
            free_count <= free_count - 1'b1;
          end
        end
        default: begin
          free_count <= free_count;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (ctl.act)
      A_ACCEPT: begin
        if (in_xfer) begin
          page_q     <= page_in;
          cursor     <= '0;
          res_page   <= '0;
          res_status <= ST_OK;
        end
      end
      A_INIT_WORD: begin
        cursor <= cursor + 1'b1;
      end
      A_FREE_WR: begin
        if (!page_ok) begin
          res_status <= ST_RANGE;
        end
      end
      A_ALLOC_START: begin
        if (free_count == '0) begin
          res_status <= ST_NO_FREE;
        end
        cursor <= start_w;
        iter   <= '0;
      end
      A_SCAN: begin
        if (found) begin
          res_page <= alloc_page[PAGE_W-1:0];
        end else begin
          cursor <= cursor_next;
          iter   <= iter + 1'b1;
          if (scan_last) begin
            res_status <= ST_NO_FREE;
          end
        end
      end
      A_POST: begin
        if (out_free) begin
          page_out   <= res_page;
          status     <= res_status;
          free_pages <= free_count;
        end
      end
      default: begin
        cursor <= cursor;
      end
    endcase
  end

  // Only one item is in flight: the step after a transfer never accepts.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted twice in a row");

  a_post_only: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ctl.act == A_POST))
    else $error("result raised outside the output step");

  a_fail_page: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != ST_OK)) |-> (page_out == '0))
    else $error("failed result carries a page number");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (32'(scan_word) < NUM_WORDS))
    else $error("scan pointer outside the bitmap");

endmodule

// ----- rtl/core/bpa_seq.sv -----
// Microcode sequencer of the page allocator: step counter, program ROM and
// conditional jump logic. Uses bpa_pkg.
module bpa_seq
  import bpa_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  bpa_cond_t cond,
  output bpa_ctl_t  ctl
);

  logic [STEP_W-1:0] pc;
  logic [STEP_W-1:0] pc_next;
  logic [STEP_W-1:0] target;
  logic              taken;

  assign ctl = ucode_rom(pc);

  always_comb begin
    unique case (ctl.cond)
      C_NEVER:      taken = 1'b0;
      C_ALWAYS:     taken = 1'b1;
      C_DISPATCH:   taken = cond.in_xfer;
      C_LAST_WORD:  taken = cond.last_word;
      C_COUNT_ZERO: taken = cond.count_zero;
      C_SCAN_DONE:  taken = cond.scan_done;
      C_OUT_FREE:   taken = cond.out_free;
      default:      taken = 1'b0;
    endcase
    // A dispatch jump takes its target from the mode of the arriving item.
    target = (ctl.cond == C_DISPATCH) ? dispatch(cond.mode) : ctl.target;
    if (taken) begin
      pc_next = target;
    end else if (ctl.hold) begin
      pc_next = pc;
    end else begin
      pc_next = pc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_FETCH;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// ----- dv/tb_bitmap_page_allocator.sv -----
// Self-checking testbench for bitmap_page_allocator: directed and random
// requests with register writes; results checked by typed rows or a predictor.
// Depends on bpa_pkg and the RTL top bitmap_page_allocator.
module tb_bitmap_page_allocator;
  import bpa_pkg::*;

  localparam int NUM_WORDS   = PAGE_COUNT / WORD_BITS;
  localparam int MAX_SHOWN   = 10;
  localparam int NUM_PHASES  = 14;
  localparam int PHASE_ITEMS = 73;
  localparam int HOLD_CYCLES = 150;
  localparam int DIR_ROWS    = 35;

  // Indexes that name no register; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [PAGE_W-1:0]   page;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
  } page_result_t;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [1:0]        sel;    // mode for a request, register index for a write
    logic [CFG_W-1:0]  arg;    // page_in for a request, data for a write
    bit                typed;
    page_result_t      want;
  } stim_row_t;

  localparam page_result_t UNTYPED = '0;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [MODE_W-1:0]    mode = MODE_NOP;
  logic [PAGE_W-1:0]    page_in = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [PAGE_W-1:0]    page_out;
  logic [STATUS_W-1:0]  status;
  logic [COUNT_W-1:0]   free_pages;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_FIRST_FREE;
  logic [CFG_W-1:0]     cfg_data = '0;

  // Predictor state.
  logic [WORD_BITS-1:0] map_bits [NUM_WORDS] = '{default: '0};
  logic [3:0]           ptr_word = '0;
  logic [COUNT_W-1:0]   free_cnt = '0;
  logic [CFG_W-1:0]     reg_first = 10'd1;
  logic [CFG_W-1:0]     reg_total = 10'd512;

  page_result_t         awaited_results [$];
  logic [PAGE_W-1:0]    granted_pages [$];
  page_result_t         typed_res = '0;
  page_result_t         predicted, oldest;
  bit                   typed_pending = 1'b0;
  bit                   no_idle = 1'b0;
  bit                   hold_req = 1'b0;
  int                   mismatch_cnt = 0;

  stim_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_ITEM, MODE_ALLOC, 10'd0,    1'b1, '{9'd0,   ST_NO_FREE, 10'd0}},
    '{ROW_ITEM, MODE_FREE,  10'd511,  1'b1, '{9'd0,   ST_OK,      10'd1}},
    '{ROW_ITEM, MODE_ALLOC, 10'd0,    1'b1, '{9'd511, ST_OK,      10'd0}},
    '{ROW_ITEM, MODE_NOP,   10'd511,  1'b1, '{9'd0,   ST_OK,      10'd0}},
    '{ROW_ITEM, MODE_FREE,  10'd0,    1'b1, '{9'd0,   ST_OK,      10'd1}},
    '{ROW_ITEM, MODE_ALLOC, 10'd0,    1'b1, '{9'd0,   ST_OK,      10'd0}},
    '{ROW_ITEM, MODE_INIT,  10'd0,    1'b1, '{9'd0,   ST_OK,      10'd511}},
    '{ROW_ITEM, MODE_ALLOC, 10'd0,    1'b1, '{9'd1,   ST_OK,      10'd510}},
    '{ROW_ITEM, MODE_FREE,  10'd1,    1'b1, '{9'd0,   ST_OK,      10'd511}},
    '{ROW_ITEM, MODE_FREE,  10'd1,    1'b1, '{9'd0,   ST_OK,      10'd512}},
    '{ROW_ITEM, MODE_FREE,  10'd5,    1'b1, '{9'd0,   ST_OK,      10'd512}},
    '{ROW_CFG,  CFG_TOTAL,  10'd33,   1'b0, UNTYPED},
    '{ROW_ITEM, MODE_FREE,  10'd33,   1'b1, '{9'd0,   ST_RANGE,   10'd512}},
    '{ROW_ITEM, MODE_FREE,  10'd32,   1'b0, UNTYPED},
    '{ROW_ITEM, MODE_ALLOC, 10'd0,    1'b0, UNTYPED},
    '{ROW_CFG,  CFG_FIRST_FREE, 10'd0,    1'b0, UNTYPED},
    '{ROW_CFG,  CFG_TOTAL,  10'd0,    1'b0, UNTYPED},
    '{ROW_ITEM, MODE_INIT,  10'd0,    1'b1, '{9'd0,   ST_OK,      10'd0}},
    '{ROW_ITEM, MODE_ALLOC, 10'd0,    1'b1, '{9'd0,   ST_NO_FREE, 10'd0}},
    '{ROW_ITEM, MODE_FREE,  10'd0,    1'b1, '{9'd0,   ST_RANGE,   10'd0}},
    '{ROW_CFG,  CFG_TOTAL,  10'd1023, 1'b0, UNTYPED},
    '{ROW_CFG,  CFG_FIRST_FREE, 10'd1023, 1'b0, UNTYPED},
    '{ROW_ITEM, MODE_INIT,  10'd0,    1'b1, '{9'd0,   ST_OK,      10'd0}},
    '{ROW_CFG,  CFG_FIRST_FREE, 10'd62,   1'b0, UNTYPED},
    '{ROW_CFG,  CFG_TOTAL,  10'd64,   1'b0, UNTYPED},
    '{ROW_ITEM, MODE_INIT,  10'd0,    1'b1, '{9'd0,   ST_OK,      10'd2}},
    '{ROW_ITEM, MODE_ALLOC, 10'd0,    1'b1, '{9'd62,  ST_OK,      10'd1}},
    '{ROW_CFG,  CFG_TOTAL,  10'd32,   1'b0, UNTYPED},
    // Pointer now sits past the words in use and the count has no bits behind it.
    '{ROW_ITEM, MODE_ALLOC, 10'd0,    1'b1, '{9'd0,   ST_NO_FREE, 10'd1}},
    '{ROW_ITEM, MODE_FREE,  10'd5,    1'b1, '{9'd0,   ST_OK,      10'd2}},
    '{ROW_ITEM, MODE_ALLOC, 10'd0,    1'b0, UNTYPED},
    '{ROW_CFG,  CFG_FIRST_FREE, 10'd512,  1'b0, UNTYPED},
    '{ROW_CFG,  CFG_TOTAL,  10'd512,  1'b0, UNTYPED},
    '{ROW_ITEM, MODE_INIT,  10'd0,    1'b1, '{9'd0,   ST_OK,      10'd0}},
    '{ROW_ITEM, MODE_ALLOC, 10'd511,  1'b1, '{9'd0,   ST_NO_FREE, 10'd0}}
  };

  bitmap_page_allocator u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .page_in    (page_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .page_out   (page_out),
    .status     (status),
    .free_pages (free_pages),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  // Bits of word w that belong to pages below t.
  function automatic logic [WORD_BITS-1:0] pages_below(input int w, input int t);
    int span;
    span = t - w * WORD_BITS;
    if (span >= WORD_BITS) return '1;
    if (span <= 0) return '0;
    return {WORD_BITS{1'b1}} >> (WORD_BITS - span);
  endfunction

  function automatic page_result_t model_page_op(input logic [MODE_W-1:0] m,
                                                 input logic [PAGE_W-1:0] pg);
    page_result_t r;
    int t, used, w, b, pi;
    logic [WORD_BITS-1:0] v;
    bit found;
    t = (reg_total > PAGE_COUNT) ? PAGE_COUNT : int'(reg_total);
    used = (t + WORD_BITS - 1) / WORD_BITS;
    pi = int'(pg);
    r = '{page: '0, status: ST_OK, count: '0};
    found = 1'b0;
    case (m)
      MODE_INIT: begin
        for (int i = 0; i < NUM_WORDS; i++) map_bits[i] = '0;
        free_cnt = '0;
        for (int p = int'(reg_first); p < t; p++) begin
          map_bits[p / WORD_BITS][p % WORD_BITS] = 1'b1;
          free_cnt++;
        end
        granted_pages.delete();
      end
      MODE_ALLOC: begin
        if (free_cnt == 0) begin
          r.status = ST_NO_FREE;
        end else begin
          w = (ptr_word < used) ? int'(ptr_word) : 0;
          for (int i = 0; i < used && !found; i++) begin
            v = map_bits[w] & pages_below(w, t);
            if (v != '0) begin
              b = 0;
              while (!v[b]) b++;
              map_bits[w][b] = 1'b0;
              ptr_word = 4'(w);
              r.page = PAGE_W'(w * WORD_BITS + b);
              free_cnt--;
              found = 1'b1;
              granted_pages.push_back(r.page);
            end else begin
              w = (w + 1 >= used) ? 0 : w + 1;
            end
          end
          if (!found) r.status = ST_NO_FREE;
        end
      end
      MODE_FREE: begin
        if (pi >= t) begin
          r.status = ST_RANGE;
        end else begin
          map_bits[pi / WORD_BITS][pi % WORD_BITS] = 1'b1;
          if (free_cnt < t) free_cnt++;
        end
      end
      default: ;
    endcase
    r.count = free_cnt;
    return r;
  endfunction

  // Everything is sampled at the rising edge, where inputs have been stable
  // since the falling edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_SHOWN)
            $display("unexpected result: page_out %0d status %0d free_pages %0d",
                     page_out, status, free_pages);
        end else begin
          oldest = awaited_results.pop_front();
          if (page_out !== oldest.page || status !== oldest.status ||
              free_pages !== oldest.count) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_SHOWN)
              $display("mismatch: page_out exp %0d got %0d, status exp %0d got %0d, %s%0d got %0d",
                       oldest.page, page_out, oldest.status, status,
                       "free_pages exp ", oldest.count, free_pages);
          end
        end
      end
      if (in_valid && in_ready) begin
        predicted = model_page_op(mode, page_in);
        awaited_results.push_back(typed_pending ? typed_res : predicted);
        typed_pending = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_FIRST_FREE) reg_first = cfg_data;
        else if (cfg_index == CFG_TOTAL) reg_total = cfg_data;
      end
    end
  end

  // Result side: random stalls, plus one long hold-off when asked for.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ready = no_idle || ($urandom_range(99) >= 38);
    end
  end

  // Entered and left at a falling edge; valid stays high into the next item
  // unless the sender decides to idle.
  task automatic send_item(input logic [MODE_W-1:0] m, input logic [PAGE_W-1:0] pg);
    while (!no_idle && $urandom_range(99) < 38) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    mode = m;
    page_in = pg;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle_block();
    in_valid = 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Mostly allocations and frees of pages handed out earlier, with some
  // random frees (double or out of range), no-ops and re-initializations.
  task automatic run_phase(input int ph);
    int pick, idx;
    logic [MODE_W-1:0] m;
    logic [PAGE_W-1:0] pg;
    if ($urandom_range(99) < 90) send_item(MODE_INIT, PAGE_W'($urandom_range(511)));
    for (int k = 0; k < PHASE_ITEMS; k++) begin
      if ((ph == 3 && k == 20) || (ph == 12 && k == 10)) hold_req = 1'b1;
      pick = $urandom_range(99);
      pg = PAGE_W'($urandom_range(511));
      if (pick < 50) begin
        m = MODE_ALLOC;
      end else if (pick < 78 && granted_pages.size() > 0) begin
        m = MODE_FREE;
        idx = $urandom_range(granted_pages.size() - 1);
        pg = granted_pages[idx];
        granted_pages.delete(idx);
      end else if (pick < 88) begin
        m = MODE_FREE;
      end else if (pick < 95) begin
        m = MODE_NOP;
      end else begin
        m = MODE_INIT;
      end
      send_item(m, pg);
    end
  endtask

  initial begin
    logic [CFG_W-1:0] ffp, tot;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        settle_block();
        write_reg(dir_rows[r].sel, dir_rows[r].arg);
      end else begin
        typed_pending = dir_rows[r].typed;
        typed_res = dir_rows[r].want;
        send_item(dir_rows[r].sel, dir_rows[r].arg[PAGE_W-1:0]);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:  begin ffp = 10'd1;    tot = 10'd512;  end
        1:  begin ffp = 10'd0;    tot = 10'd32;   end
        2:  begin ffp = 10'd0;    tot = 10'd1;    end
        3:  begin ffp = 10'd1;    tot = 10'd33;   end
        4:  begin ffp = 10'd5;    tot = 10'd64;   end
        5:  begin ffp = 10'd31;   tot = 10'd100;  end
        6:  begin ffp = 10'd0;    tot = 10'd0;    end
        7:  begin ffp = 10'd1023; tot = 10'd1023; end
        9:  begin ffp = 10'd200;  tot = 10'd512;  end
        10: begin ffp = 10'd0;    tot = 10'd1023; end
        11: begin
          tot = CFG_W'($urandom_range(96, 1));
          ffp = CFG_W'($urandom_range(tot));
        end
        12: begin ffp = 10'd512;  tot = 10'd512;  end
        13: begin
          ffp = CFG_W'($urandom_range(1023));
          tot = CFG_W'($urandom_range(1023));
        end
        default: begin
          tot = CFG_W'($urandom_range(512, 1));
          ffp = CFG_W'($urandom_range(tot));
        end
      endcase
      settle_block();
      no_idle = (ph == 9 || ph == 10);
      if ($urandom_range(1)) begin
        write_reg(CFG_TOTAL, tot);
        write_reg(CFG_FIRST_FREE, ffp);
      end else begin
        write_reg(CFG_FIRST_FREE, ffp);
        write_reg(CFG_TOTAL, tot);
      end
      if (ph == 4) begin
        write_reg(CFG_SPARE_A, CFG_W'($urandom_range(1023)));
        write_reg(CFG_SPARE_B, CFG_W'($urandom_range(1023)));
      end
      run_phase(ph);
    end

    settle_block();
    repeat (30) @(posedge clk);
    if (mismatch_cnt == 0 && awaited_results.size() == 0) begin
      $display("tb_bitmap_page_allocator: PASS");
    end else begin
      $display("tb_bitmap_page_allocator: FAIL");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("tb_bitmap_page_allocator: FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/bpa_pkg.sv
rtl/core/bpa_seq.sv
rtl/core/bitmap_page_allocator.sv
dv/tb_bitmap_page_allocator.sv
